[src/matrix_multiply_accumulate_macros.svh]
`ifndef MATRIX_MULTIPLY_ACCUMULATE_MACROS_SVH
`define MATRIX_MULTIPLY_ACCUMULATE_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define MMA_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("mma check failed");

// next-cycle implication, sampled on clk, off during reset
`define MMA_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("mma check failed");

`endif

[src/mma_pkg.sv]
package mma_pkg;

	localparam int IDX_W       = 3;
	localparam int IDX_LIM     = 2 ** IDX_W;
	localparam int VAL_W       = 16;
	localparam int ACC_W       = 32;
	localparam int PROD_W      = 2 * VAL_W;
	localparam int SUM_W       = 36;
	localparam int MS_W        = 4;
	localparam int MS_RESET    = 8;
	localparam int MAX_DIM_DEF = 8;

	typedef struct packed {
		logic vld;
		logic first;
		logic last;
	} mac_ctl_t;

endpackage

[src/mma_mac.sv]
module mma_mac import mma_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  mac_ctl_t                ctl_s1,
	input  logic signed [VAL_W-1:0] a_s1,
	input  logic signed [VAL_W-1:0] b_s1,
	input  logic signed [ACC_W-1:0] c_s1,
	input  logic                    done_clr,
	output logic                    done,
	output logic signed [ACC_W-1:0] sat_val
);

	mac_ctl_t                  ctl_s2;
	logic signed [PROD_W-1:0]  prod_s2;
	logic signed [ACC_W-1:0]   c_s2;
	logic signed [SUM_W-1:0]   acc_q;
	logic                      done_q;
	logic [SUM_W-ACC_W:0]      acc_hi;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
			done_q <= 1'b0;
		end else begin
			ctl_s2 <= ctl_s1;
			if (ctl_s2.vld && ctl_s2.last) begin
				done_q <= 1'b1;
			end else if (done_clr) begin
				done_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		prod_s2 <= PROD_W'(a_s1) * PROD_W'(b_s1);
		c_s2    <= c_s1;
		if (ctl_s2.vld) begin
			acc_q <= (ctl_s2.first ? SUM_W'(c_s2) : acc_q) + SUM_W'(prod_s2);
		end
	end

	assign acc_hi = acc_q[SUM_W-1:ACC_W-1];

	always_comb begin
		priority if (acc_hi == '0 || acc_hi == '1) begin
			sat_val = acc_q[ACC_W-1:0];
		end else if (acc_q[SUM_W-1]) begin
			sat_val = {1'b1, {(ACC_W-1){1'b0}}};
		end else begin
			sat_val = {1'b0, {(ACC_W-1){1'b1}}};
		end
	end

	assign done = done_q;

endmodule

[src/matrix_multiply_accumulate.sv]
// channel   | handshake           | payload
// ----------+---------------------+------------------------------------------
// load      | ld_valid, ld_stall  | row, col, a_val, b_val, c_val, load_done
// result    | res_valid, res_stall| out_row, out_col, sum_val, last_result
// config    | cfg_we              | cfg_data (matrix size)
//
// Plain loads are taken back to back while idle. A load with load_done starts
// a compute of n*n elements: one memory read of A and B per k through the single
// multiply-accumulate unit, then the read, multiply and accumulate stages. Loads
// stall for the whole compute.
// No clearing pass after reset; stores hold garbage until loaded.
// A stalled result holds the compute at the write-back of the next element.
`include "matrix_multiply_accumulate_macros.svh"

module matrix_multiply_accumulate import mma_pkg::*; #(
	parameter int MAX_DIM = MAX_DIM_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic [MS_W-1:0]         cfg_data,
	input  logic                    ld_valid,
	output logic                    ld_stall,
	input  logic [IDX_W-1:0]        row,
	input  logic [IDX_W-1:0]        col,
	input  logic signed [VAL_W-1:0] a_val,
	input  logic signed [VAL_W-1:0] b_val,
	input  logic signed [ACC_W-1:0] c_val,
	input  logic                    load_done,
	output logic                    res_valid,
	input  logic                    res_stall,
	output logic [IDX_W-1:0]        out_row,
	output logic [IDX_W-1:0]        out_col,
	output logic signed [ACC_W-1:0] sum_val,
	output logic                    last_result
);

	localparam int DIM_LIM = (MAX_DIM < IDX_LIM) ? MAX_DIM : IDX_LIM;
	localparam int DEPTH   = MAX_DIM * MAX_DIM;
	localparam int AW      = $clog2(DEPTH);
	localparam int CW      = (DIM_LIM > 1) ? $clog2(DIM_LIM) : 1;
	localparam int DW      = $clog2(DIM_LIM + 1);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_ISSUE = 2'd1;
	localparam logic [1:0] ST_WAIT  = 2'd2;

	logic [1:0]              state_q;
	logic [MS_W-1:0]         ms_q;
	logic [DW-1:0]           dim_q;
	logic [DW-1:0]           dim_nxt;
	logic [CW-1:0]           dim_last;
	logic [CW-1:0]           i_q;
	logic [CW-1:0]           j_q;
	logic [CW-1:0]           k_q;
	mac_ctl_t                ctl_s1;

	logic [2*VAL_W-1:0]      ab_mem [DEPTH];
	logic signed [ACC_W-1:0] c_mem [DEPTH];
	logic signed [VAL_W-1:0] a_rd_s1;
	logic signed [VAL_W-1:0] b_rd_s1;
	logic signed [ACC_W-1:0] c_rd_s1;

	logic                    ld_acc;
	logic                    ld_in_range;
	logic [AW-1:0]           ld_addr;
	logic [AW-1:0]           a_raddr;
	logic [AW-1:0]           b_raddr;
	logic [AW-1:0]           c_addr;

	logic                    mac_done;
	logic signed [ACC_W-1:0] mac_sat;
	logic                    emit;
	logic                    elem_last;
	logic                    res_valid_q;
	logic [IDX_W-1:0]        out_row_q;
	logic [IDX_W-1:0]        out_col_q;
	logic signed [ACC_W-1:0] sum_val_q;
	logic                    last_result_q;

	always_comb begin
		priority if (ms_q == '0) begin
			dim_nxt = DW'(1);
		end else if (int'(ms_q) > DIM_LIM) begin
			dim_nxt = DW'(DIM_LIM);
		end else begin
			dim_nxt = DW'(ms_q);
		end
	end

	assign dim_last    = CW'(dim_q - DW'(1));
	assign ld_stall    = (state_q != ST_IDLE);
	assign ld_acc      = ld_valid && !ld_stall;
	assign ld_in_range = (int'(row) < MAX_DIM) && (int'(col) < MAX_DIM);
	assign ld_addr     = AW'(int'(row) * MAX_DIM + int'(col));
	assign a_raddr     = AW'(int'(i_q) * MAX_DIM + int'(k_q));
	assign b_raddr     = AW'(int'(k_q) * MAX_DIM + int'(j_q));
	assign c_addr      = AW'(int'(i_q) * MAX_DIM + int'(j_q));
	assign emit        = (state_q == ST_WAIT) && mac_done && (!res_valid_q || !res_stall);
	assign elem_last   = (i_q == dim_last) && (j_q == dim_last);

	always_ff @(posedge clk) begin
		if (ld_acc && ld_in_range) begin
			ab_mem[ld_addr] <= {a_val, b_val};
		end
		a_rd_s1 <= ab_mem[a_raddr][2*VAL_W-1:VAL_W];
		b_rd_s1 <= ab_mem[b_raddr][VAL_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			c_mem[c_addr] <= mac_sat;
		end else if (ld_acc && ld_in_range) begin
			c_mem[ld_addr] <= c_val;
		end
		c_rd_s1 <= c_mem[c_addr];
	end

	mma_mac u_mac (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl_s1   (ctl_s1),
		.a_s1     (a_rd_s1),
		.b_s1     (b_rd_s1),
		.c_s1     (c_rd_s1),
		.done_clr (emit),
		.done     (mac_done),
		.sat_val  (mac_sat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			ms_q        <= MS_W'(MS_RESET);
			dim_q       <= '0;
			i_q         <= '0;
			j_q         <= '0;
			k_q         <= '0;
			ctl_s1      <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				ms_q <= cfg_data;
			end
			ctl_s1.vld   <= (state_q == ST_ISSUE);
			ctl_s1.first <= (state_q == ST_ISSUE) && (k_q == '0);
			ctl_s1.last  <= (state_q == ST_ISSUE) && (k_q == dim_last);
			if (emit) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (ld_acc && load_done) begin
						dim_q   <= dim_nxt;
						i_q     <= '0;
						j_q     <= '0;
						k_q     <= '0;
						state_q <= ST_ISSUE;
					end
				end
				ST_ISSUE: begin
					if (k_q == dim_last) begin
						state_q <= ST_WAIT;
					end else begin
						k_q <= k_q + CW'(1);
					end
				end
				ST_WAIT: begin
					if (emit) begin
						k_q <= '0;
						if (elem_last) begin
							state_q <= ST_IDLE;
						end else begin
							state_q <= ST_ISSUE;
							if (j_q == dim_last) begin
								j_q <= '0;
								i_q <= i_q + CW'(1);
							end else begin
								j_q <= j_q + CW'(1);
							end
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_row_q     <= IDX_W'(i_q);
			out_col_q     <= IDX_W'(j_q);
			sum_val_q     <= mac_sat;
			last_result_q <= elem_last;
		end
	end

	assign res_valid   = res_valid_q;
	assign out_row     = out_row_q;
	assign out_col     = out_col_q;
	assign sum_val     = sum_val_q;
	assign last_result = last_result_q;

	`MMA_ASSERT_NOW(a_done_in_wait, mac_done, state_q == ST_WAIT)
	`MMA_ASSERT_NOW(a_mac_busy, ctl_s1.vld, state_q == ST_ISSUE || state_q == ST_WAIT)
	`MMA_ASSERT_NEXT(a_start, ld_acc && load_done, state_q == ST_ISSUE && {i_q, j_q, k_q} == '0)

endmodule

[verif/tb_matrix_multiply_accumulate.sv]
`timescale 1ns / 100ps

module tb_matrix_multiply_accumulate;
	import mma_pkg::*;

	localparam int DIM_LIM     = (MAX_DIM_DEF < IDX_LIM) ? MAX_DIM_DEF : IDX_LIM;
	localparam int STORE_DEPTH = MAX_DIM_DEF * MAX_DIM_DEF;
	localparam int DRAIN       = 40;
	localparam int QUIET_LIMIT = 4000;
	localparam longint SUM_MAX = 64'sd2147483647;
	localparam longint SUM_MIN = -64'sd2147483648;

	typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

	typedef struct packed {
		logic [IDX_W-1:0]        row;
		logic [IDX_W-1:0]        col;
		logic signed [VAL_W-1:0] a;
		logic signed [VAL_W-1:0] b;
		logic signed [ACC_W-1:0] c;
		logic                    done;
	} load_req_t;

	typedef struct packed {
		logic [IDX_W-1:0]        row;
		logic [IDX_W-1:0]        col;
		logic signed [ACC_W-1:0] sum;
		logic                    last;
	} sum_res_t;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    cfg_we = 1'b0;
	logic [MS_W-1:0]         cfg_data = '0;
	logic                    ld_valid = 1'b0;
	logic                    ld_stall;
	logic                    res_valid;
	logic                    res_stall = 1'b0;
	logic [IDX_W-1:0]        out_row;
	logic [IDX_W-1:0]        out_col;
	logic signed [ACC_W-1:0] sum_val;
	logic                    last_result;
	load_req_t               cur_req = '0;

	load_req_t pending_loads[$];
	sum_res_t  expected_sums[$];

	logic signed [VAL_W-1:0] a_mem [STORE_DEPTH];
	logic signed [VAL_W-1:0] b_mem [STORE_DEPTH];
	logic signed [ACC_W-1:0] c_mem [STORE_DEPTH];
	bit                      pos_loaded [STORE_DEPTH];
	int                      size_reg = MS_RESET;

	int send_pct = 0;
	int stall_pct = 0;
	int loads_queued = 0;
	int loads_taken = 0;
	int mismatches = 0;
	int quiet_cycles = 0;

	matrix_multiply_accumulate uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_data   (cfg_data),
		.ld_valid   (ld_valid),
		.ld_stall   (ld_stall),
		.row        (cur_req.row),
		.col        (cur_req.col),
		.a_val      (cur_req.a),
		.b_val      (cur_req.b),
		.c_val      (cur_req.c),
		.load_done  (cur_req.done),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.out_row    (out_row),
		.out_col    (out_col),
		.sum_val    (sum_val),
		.last_result(last_result)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	function automatic int dim_of(input int v);
		if (v < 1) return 1;
		if (v > DIM_LIM) return DIM_LIM;
		return v;
	endfunction

	task automatic apply_load(input load_req_t req);
		int dim;
		int idx;
		longint acc;
		sum_res_t res;
		if (req.row < MAX_DIM_DEF && req.col < MAX_DIM_DEF) begin
			idx = req.row * MAX_DIM_DEF + req.col;
			a_mem[idx] = req.a;
			b_mem[idx] = req.b;
			c_mem[idx] = req.c;
		end
		if (!req.done)
			return;
		dim = dim_of(size_reg);
		for (int i = 0; i < dim; i++) begin
			for (int j = 0; j < dim; j++) begin
				acc = longint'(c_mem[i * MAX_DIM_DEF + j]);
				for (int k = 0; k < dim; k++)
					acc += longint'(a_mem[i * MAX_DIM_DEF + k]) *
						longint'(b_mem[k * MAX_DIM_DEF + j]);
				if (acc > SUM_MAX)
					acc = SUM_MAX;
				if (acc < SUM_MIN)
					acc = SUM_MIN;
				c_mem[i * MAX_DIM_DEF + j] = acc[ACC_W-1:0];
				res.row = IDX_W'(i);
				res.col = IDX_W'(j);
				res.sum = acc[ACC_W-1:0];
				res.last = (i == dim - 1) && (j == dim - 1);
				expected_sums.push_back(res);
			end
		end
	endtask

	task automatic note_mismatch(input string what, input sum_res_t want, input sum_res_t got);
		mismatches++;
		if (mismatches <= 10)
			$display("%s: expected (%0d,%0d) %0d last %0b, got (%0d,%0d) %0d last %0b",
				what, want.row, want.col, want.sum, want.last,
				got.row, got.col, got.sum, got.last);
	endtask

	always @(posedge clk) begin
		if (arst_n && (!ld_valid || !ld_stall)) begin
			if (ld_valid) begin
				apply_load(cur_req);
				loads_taken++;
			end
			if (pending_loads.size() != 0 && $urandom_range(0, 99) >= send_pct) begin
				cur_req <= pending_loads.pop_front();
				ld_valid <= 1'b1;
			end else begin
				ld_valid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		sum_res_t got;
		sum_res_t want;
		if (arst_n) begin
			res_stall <= ($urandom_range(0, 99) < stall_pct);
			if (res_valid && !res_stall) begin
				got = '{row: out_row, col: out_col, sum: sum_val, last: last_result};
				if (expected_sums.size() == 0) begin
					note_mismatch("unexpected result", '0, got);
				end else begin
					want = expected_sums.pop_front();
					if (got.row !== want.row || got.col !== want.col ||
						got.sum !== want.sum || got.last !== want.last)
						note_mismatch("result mismatch", want, got);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((ld_valid && !ld_stall) || (res_valid && !res_stall))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("status: fail");
				$finish;
			end
		end
	end

	task automatic queue_load(input int r, input int c, input logic signed [VAL_W-1:0] av,
		input logic signed [VAL_W-1:0] bv, input logic signed [ACC_W-1:0] cv, input bit done);
		load_req_t req;
		req.row = IDX_W'(r);
		req.col = IDX_W'(c);
		req.a = av;
		req.b = bv;
		req.c = cv;
		req.done = done;
		pos_loaded[r * MAX_DIM_DEF + c] = 1'b1;
		loads_queued++;
		pending_loads.push_back(req);
	endtask

	function automatic logic signed [VAL_W-1:0] pick_q88();
		case ($urandom_range(0, 3))
			0: return VAL_W'(int'($urandom_range(0, 1023)) - 512);
			1: begin
				case ($urandom_range(0, 3))
					0: return 16'sh8000;
					1: return 16'sh7fff;
					2: return 16'sh0000;
					default: return -16'sd1;
				endcase
			end
			default: return VAL_W'($urandom);
		endcase
	endfunction

	function automatic logic signed [ACC_W-1:0] pick_q1616();
		case ($urandom_range(0, 3))
			0: return int'($urandom_range(0, 1 << 20)) - (1 << 19);
			1: begin
				case ($urandom_range(0, 2))
					0: return 32'sh80000000;
					1: return 32'sh7fffffff;
					default: return 32'sh00000000;
				endcase
			end
			default: return $urandom;
		endcase
	endfunction

	task automatic load_random(input int r, input int c, input bit done);
		queue_load(r, c, pick_q88(), pick_q88(), pick_q1616(), done);
	endtask

	task automatic settle();
		while (loads_taken != loads_queued || expected_sums.size() != 0)
			@(posedge clk);
		repeat (DRAIN) @(posedge clk);
	endtask

	task automatic write_size(input int v);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_data <= MS_W'(v);
		@(posedge clk);
		cfg_we <= 1'b0;
		size_reg = v;
	endtask

	task automatic set_idling(input idle_mode_t mode);
		case (mode)
			IDLE_SEND: begin
				send_pct = 66;
				stall_pct = 0;
			end
			IDLE_RECV: begin
				send_pct = 0;
				stall_pct = 66;
			end
			IDLE_BOTH: begin
				send_pct = 11;
				stall_pct = 11;
			end
			default: begin
				send_pct = 0;
				stall_pct = 0;
			end
		endcase
	endtask

	task automatic run_phase(input int size_val, input idle_mode_t mode, input int budget);
		int dim;
		int left;
		write_size(size_val);
		set_idling(mode);
		dim = dim_of(size_val);
		left = budget;
		while (left > 0) begin
			if ($urandom_range(0, 9) == 0) begin
				load_random($urandom_range(0, IDX_LIM - 1), $urandom_range(0, IDX_LIM - 1),
					1'b0);
				left--;
				continue;
			end
			for (int r = 0; r < dim; r++)
				for (int c = 0; c < dim; c++)
					if (!pos_loaded[r * MAX_DIM_DEF + c]) begin
						load_random(r, c, 1'b0);
						left--;
					end
			repeat ($urandom_range(0, 3)) begin
				if ($urandom_range(0, 1))
					load_random($urandom_range(0, dim - 1), $urandom_range(0, dim - 1),
						1'b0);
				else
					load_random($urandom_range(0, IDX_LIM - 1),
						$urandom_range(0, IDX_LIM - 1), 1'b0);
				left--;
			end
			load_random($urandom_range(0, IDX_LIM - 1), $urandom_range(0, IDX_LIM - 1),
				1'b1);
			left--;
		end
		settle();
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		write_size(1);
		set_idling(IDLE_NONE);
		queue_load(0, 0, 16'sh8000, 16'sh8000, 32'sh7fffffff, 1'b1);
		queue_load(0, 0, 16'sh7fff, 16'sh8000, 32'sh80000000, 1'b1);
		queue_load(0, 0, 16'sh0100, 16'sh0100, 32'sh00000000, 1'b0);
		queue_load(7, 7, 16'sh7fff, 16'sh7fff, -32'sd1, 1'b0);
		queue_load(7, 7, 16'sh0000, 16'sh0000, 32'sh00000000, 1'b1);
		queue_load(3, 5, -16'sd1, -16'sd1, 32'sh00000001, 1'b1);
		settle();

		write_size(2);
		queue_load(0, 1, 16'sh7fff, 16'sh8000, 32'sh7fffffff, 1'b0);
		queue_load(1, 0, 16'sh8000, 16'sh7fff, 32'sh80000000, 1'b0);
		queue_load(1, 1, 16'sh0180, -16'sh0240, 32'sh00012345, 1'b0);
		queue_load(0, 0, -16'sh0100, 16'sh0200, -32'sh00030000, 1'b1);
		queue_load(6, 2, 16'sh1234, 16'sh4321, 32'sh00000000, 1'b1);
		settle();

		run_phase(3, IDLE_NONE, 25);
		run_phase(2, IDLE_SEND, 20);
		run_phase(15, IDLE_RECV, 50);
		run_phase(0, IDLE_BOTH, 12);
		run_phase(8, IDLE_NONE, 10);
		run_phase(4, IDLE_RECV, 20);
		run_phase(1, IDLE_SEND, 12);
		run_phase(9, IDLE_BOTH, 8);

		if (mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
